// ===== rtl/s2trie_pkg.sv =====
// -----------------------------------------------------------------------------
// s2trie_pkg
// Shared types and constants of the stride-2 trie route table: node pool
// size, index widths, node record and the node store write bundle.
// -----------------------------------------------------------------------------
package s2trie_pkg;

   localparam int NODE_POOL = 4096;
   localparam int IDX_W     = $clog2(NODE_POOL);
   localparam int CNT_W     = $clog2(NODE_POOL) + 1;
   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 6;
   localparam int PORT_W    = 16;

   localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(32);
   localparam logic [PORT_W-1:0] NO_PORT = '1;

   // item function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // result status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      idx_type [3:0]     links;
      logic [PORT_W-1:0] even_slot;
      logic [PORT_W-1:0] odd_slot;
      logic [ADDR_W-1:0] network;
      logic [LEN_W-1:0]  length;
   } node_type;

   typedef struct packed {
      idx_type  addr;
      logic     we_links;
      logic     we_even;
      logic     we_odd;
      logic     we_net;
      logic     we_len;
      node_type data;
   } wr_type;

   // two-bit digit of the level; a lone last bit is padded with zero
   function automatic logic [1:0] digit_of(input logic [1:0] top, input logic [LEN_W-1:0] rem);
      logic [1:0] d;
      begin
         d = (rem == LEN_W'(1)) ? {top[1], 1'b0} : top;
         return d;
      end
   endfunction

   // prefix bits left after one level
   function automatic logic [LEN_W-1:0] rem_step(input logic [LEN_W-1:0] rem);
      logic [LEN_W-1:0] r;
      begin
         r = (rem > LEN_W'(2)) ? rem - LEN_W'(2) : '0;
         return r;
      end
   endfunction

endpackage

// ===== rtl/s2trie_node_store.sv =====
// -----------------------------------------------------------------------------
// s2trie_node_store
// Node pool of the trie: one write port, one registered read port. The root
// lives in flip-flops with its reset values; pool entries are plain memory.
// -----------------------------------------------------------------------------
module s2trie_node_store (
   input  logic                clock,
   input  logic                reset,
   input  s2trie_pkg::idx_type rd_addr,
   output s2trie_pkg::node_type rd_node,
   input  s2trie_pkg::wr_type  wr
);
   import s2trie_pkg::*;

   idx_type [3:0]     link_mem [NODE_POOL];
   logic [PORT_W-1:0] even_mem [NODE_POOL];
   logic [PORT_W-1:0] odd_mem  [NODE_POOL];
   logic [ADDR_W-1:0] net_mem  [NODE_POOL];
   logic [LEN_W-1:0]  len_mem  [NODE_POOL];

   node_type root_ff;
   node_type mem_rd_ff;
   logic     rd_root_ff;

   logic     wr_root;
   assign wr_root = (wr.addr == '0);

   // root record
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff.links     <= '0;
         root_ff.even_slot <= '0;
         root_ff.odd_slot  <= NO_PORT;
         root_ff.network   <= '0;
         root_ff.length    <= '0;
      end else if (wr_root) begin
         if (wr.we_links) root_ff.links     <= wr.data.links;
         if (wr.we_even)  root_ff.even_slot <= wr.data.even_slot;
         if (wr.we_odd)   root_ff.odd_slot  <= wr.data.odd_slot;
         if (wr.we_net)   root_ff.network   <= wr.data.network;
         if (wr.we_len)   root_ff.length    <= wr.data.length;
      end
   end

   // pool memory
   always_ff @(posedge clock) begin
      if (!wr_root) begin
         if (wr.we_links) link_mem[wr.addr] <= wr.data.links;
         if (wr.we_even)  even_mem[wr.addr] <= wr.data.even_slot;
         if (wr.we_odd)   odd_mem[wr.addr]  <= wr.data.odd_slot;
         if (wr.we_net)   net_mem[wr.addr]  <= wr.data.network;
         if (wr.we_len)   len_mem[wr.addr]  <= wr.data.length;
      end
      mem_rd_ff.links     <= link_mem[rd_addr];
      mem_rd_ff.even_slot <= even_mem[rd_addr];
      mem_rd_ff.odd_slot  <= odd_mem[rd_addr];
      mem_rd_ff.network   <= net_mem[rd_addr];
      mem_rd_ff.length    <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_root_ff <= 1'b1;
      end else begin
         rd_root_ff <= (rd_addr == '0);
      end
   end

   assign rd_node = rd_root_ff ? root_ff : mem_rd_ff;

endmodule

// ===== rtl/stride2_trie_route_table_core.sv =====
// -----------------------------------------------------------------------------
// stride2_trie_route_table_core
// Route table kept as a trie of two-bit strides: inserts routes with node
// allocation from a bounded pool, and looks up the deepest matching node.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | func, ip_addr, prefix_len, route_port
//   rsp     | out       | rsp_valid/rsp_stall | status, found, out_port, net_addr,
//           |           |                     | net_prefix
//
// One beat in gives one beat out. An unstalled item runs from accept to result
// beat as follows: it walks the trie one level at a time (one node store read
// each) and then decides; on insert it writes the parent link and then each
// new node, or updates an existing final node; then it offers the result beat.
// Walked and new levels together never exceed 16. The next request beat is
// taken in the cycle after the result beat leaves; the node store's single read
// port sets the pace. req_stall stays high during reset and from accept until the
// result beat leaves; rsp_stall holds the result in place. Reset (synchronous,
// active high) restores the root, with port zero in its even slot and its odd
// slot empty, and a pool of one node; no clearing pass is needed.
// -----------------------------------------------------------------------------
module stride2_trie_route_table_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [s2trie_pkg::ADDR_W-1:0]    req_ip_addr,
   input  logic [s2trie_pkg::LEN_W-1:0]     req_prefix_len,
   input  logic [s2trie_pkg::PORT_W-1:0]    req_route_port,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic                             rsp_found,
   output logic [s2trie_pkg::PORT_W-1:0]    rsp_out_port,
   output logic [s2trie_pkg::ADDR_W-1:0]    rsp_net_addr,
   output logic [s2trie_pkg::LEN_W-1:0]     rsp_net_prefix
);
   import s2trie_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_LINK  = 6'b000100,
      ST_NODE  = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // item context
   logic              func_ff,  func_in;
   logic [ADDR_W-1:0] ip_ff,    ip_in;
   logic [ADDR_W-1:0] addr_ff,  addr_in;   // address, shifted one digit per level
   logic [LEN_W-1:0]  len_ff,   len_in;
   logic [LEN_W-1:0]  rem_ff,   rem_in;    // prefix bits not yet consumed
   logic [PORT_W-1:0] port_ff,  port_in;
   idx_type           cur_ff,   cur_in;
   logic [CNT_W-1:0]  used_ff,  used_in;

   // result beat
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_found_ff,  rsp_found_in;
   logic [PORT_W-1:0] rsp_port_ff,   rsp_port_in;
   logic [ADDR_W-1:0] rsp_net_ff,    rsp_net_in;
   logic [LEN_W-1:0]  rsp_pfx_ff,    rsp_pfx_in;

   node_type rd_node;
   wr_type   wr;

   logic [1:0]        digit;
   idx_type           child;
   logic [CNT_W-1:0]  need;
   logic [CNT_W-1:0]  free_cnt;
   logic [PORT_W-1:0] hit_port;
   logic              req_beat;

   // ---------------------------------------------------------------------------
   // Node store; the read address follows the next current node so that the
   // read data always belongs to cur_ff.
   // ---------------------------------------------------------------------------
   s2trie_node_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (cur_in),
      .rd_node (rd_node),
      .wr      (wr)
   );

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;

   assign digit    = digit_of(addr_ff[ADDR_W-1 -: 2], rem_ff);
   assign child    = rd_node.links[digit];
   // levels still missing below the current node, and nodes left in the pool
   assign need     = CNT_W'((LEN_W'(rem_ff) + LEN_W'(1)) >> 1);
   assign free_cnt = CNT_W'(NODE_POOL) - used_ff;
   assign hit_port = len_ff[0] ? rd_node.odd_slot : rd_node.even_slot;

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      ip_in         = ip_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      rem_in        = rem_ff;
      port_in       = port_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_net_in    = rsp_net_ff;
      rsp_pfx_in    = rsp_pfx_ff;
      wr            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               // clamp lengths above 32, start at the root
               func_in  = req_func;
               ip_in    = req_ip_addr;
               addr_in  = req_ip_addr;
               len_in   = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
               rem_in   = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
               port_in  = req_route_port;
               cur_in   = '0;
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            if (rem_ff != '0 && child != '0) begin
               // advance one level along an existing link
               cur_in  = child;
               addr_in = addr_ff << 2;
               rem_in  = rem_step(rem_ff);
            end else if (func_ff == FUNC_LOOKUP) begin
               rsp_status_in = STATUS_DONE;
               rsp_found_in  = (hit_port != NO_PORT);
               rsp_port_in   = hit_port;
               rsp_net_in    = rd_node.network;
               rsp_pfx_in    = rd_node.length;
               state_in      = ST_RESP;
            end else begin
               rsp_found_in = 1'b0;
               rsp_port_in  = NO_PORT;
               rsp_net_in   = '0;
               rsp_pfx_in   = '0;
               if (need > free_cnt) begin
                  // drop the insert: pool cannot hold the missing levels
                  rsp_status_in = STATUS_FULL;
                  state_in      = ST_RESP;
               end else begin
                  rsp_status_in = STATUS_DONE;
                  state_in      = (rem_ff == '0) ? ST_FINAL : ST_LINK;
               end
            end
         end

         ST_LINK: begin
            // hook the first new node under the deepest existing one
            wr.addr              = cur_ff;
            wr.we_links          = 1'b1;
            wr.data.links        = rd_node.links;
            wr.data.links[digit] = used_ff[IDX_W-1:0];
            cur_in               = used_ff[IDX_W-1:0];
            addr_in              = addr_ff << 2;
            rem_in               = rem_step(rem_ff);
            state_in             = ST_NODE;
         end

         ST_NODE: begin
            // write one fresh node; its child, if any, is the next index
            wr.addr     = cur_ff;
            wr.we_links = 1'b1;
            wr.we_even  = 1'b1;
            wr.we_odd   = 1'b1;
            wr.we_net   = 1'b1;
            wr.we_len   = 1'b1;
            used_in     = used_ff + CNT_W'(1);
            if (rem_ff != '0) begin
               wr.data.links[digit] = cur_ff + IDX_W'(1);
               wr.data.even_slot    = NO_PORT;
               wr.data.odd_slot     = NO_PORT;
               cur_in               = cur_ff + IDX_W'(1);
               addr_in              = addr_ff << 2;
               rem_in               = rem_step(rem_ff);
            end else begin
               wr.data.even_slot = len_ff[0] ? NO_PORT : port_ff;
               wr.data.odd_slot  = len_ff[0] ? port_ff : NO_PORT;
               wr.data.network   = ip_ff;
               wr.data.length    = len_ff;
               state_in          = ST_RESP;
            end
         end

         ST_FINAL: begin
            // update an existing node: rewrite network and length, set one slot
            wr.addr           = cur_ff;
            wr.we_net         = 1'b1;
            wr.we_len         = 1'b1;
            wr.we_odd         = len_ff[0];
            wr.we_even        = !len_ff[0];
            wr.data.even_slot = port_ff;
            wr.data.odd_slot  = port_ff;
            wr.data.network   = ip_ff;
            wr.data.length    = len_ff;
            state_in          = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      ip_ff         <= ip_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      rem_ff        <= rem_in;
      port_ff       <= port_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_net_ff    <= rsp_net_in;
      rsp_pfx_ff    <= rsp_pfx_in;
   end

   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_out_port   = rsp_port_ff;
   assign rsp_net_addr   = rsp_net_ff;
   assign rsp_net_prefix = rsp_pfx_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result beat is pending");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(NODE_POOL))
      else $error("node pool count exceeds pool size");

   a_alloc_only_in_node: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(used_ff) |-> $past(state_ff) == ST_NODE)
      else $error("pool count moved outside node allocation");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found && rsp_out_port == NO_PORT)
      else $error("dropped insert reports a port");

endmodule
